// ----- hdl/abp_pkg.sv -----
// ============================================================================
// abp_pkg
// Shared types and constants for the alpha blend pixel pipeline.
// ============================================================================
package abp_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COV_W   = 9;   // coverage 0..256
    localparam int unsigned INDEX_W = 2;

    // Full coverage threshold and rounding bias of the channel mix
    localparam logic [COV_W-1:0] COV_FULL   = 9'd255;
    localparam int signed        ROUND_BIAS = 127;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [1:0] {
        MODE_RGBA  = 2'd0,
        MODE_RGB   = 2'd1,
        MODE_INDEX = 2'd2,
        MODE_MASK  = 2'd3
    } dest_mode_t;

    // Register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_DEST_MODE    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_GLOBAL_ALPHA = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MASK_ENABLE  = 2'd2;

    typedef struct packed {
        dest_mode_t        dest_mode;
        logic [CHAN_W-1:0] global_alpha;
        logic              mask_enable;
    } cfg_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    typedef struct packed {
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_alpha;
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_blue;
        logic [CHAN_W-1:0] dst_alpha;
        logic              span_end;
    } pixel_t;

endpackage

// ----- hdl/abp_coverage.sv -----
// ============================================================================
// abp_coverage
// Two-stage coverage unit: alpha times global alpha, then the optional mask.
// ============================================================================
module abp_coverage
    import abp_pkg::*;
(
    input  logic              clk,
    input  stage_en_t         en,
    input  cfg_t              cfg,
    input  logic [CHAN_W-1:0] src_alpha,
    input  logic [CHAN_W-1:0] mask_value,
    output logic [COV_W-1:0]  coverage
);

    logic [17:0]       prod_full;
    logic [16:0]       prod_reg;
    logic [CHAN_W-1:0] mask_reg;
    logic [25:0]       masked;
    logic [COV_W-1:0]  coverage_next;
    logic [COV_W-1:0]  coverage_reg;

    assign prod_full = ({1'b0, src_alpha} + 9'd1) * ({1'b0, cfg.global_alpha} + 9'd1);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg <= prod_full[16:0];
            mask_reg <= mask_value;
        end
    end

    assign masked = prod_reg * ({1'b0, mask_reg} + 9'd1);

    always_comb
    begin
        if (cfg.mask_enable)
            coverage_next = masked[24:16];
        else
            coverage_next = prod_reg[16:8];
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
            coverage_reg <= coverage_next;
    end

    assign coverage = coverage_reg;

endmodule

// ----- hdl/abp_mix_lane.sv -----
// ============================================================================
// abp_mix_lane
// One channel of the blend: registered product, then round, shift and add.
// ============================================================================
module abp_mix_lane
    import abp_pkg::*;
(
    input  logic              clk,
    input  stage_en_t         en,
    input  logic [COV_W-1:0]  factor,
    input  logic [CHAN_W-1:0] src,
    input  logic [CHAN_W-1:0] dst,
    output logic [CHAN_W-1:0] mix
);

    logic signed [8:0]  diff;
    logic signed [18:0] prod_next;
    logic signed [18:0] prod_reg;
    logic [CHAN_W-1:0]  dst_reg;
    logic signed [18:0] rounded;

    assign diff      = $signed({1'b0, src}) - $signed({1'b0, dst});
    assign prod_next = $signed({1'b0, factor}) * diff;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            prod_reg <= prod_next;
            dst_reg  <= dst;
        end
    end

    // Add the rounding bias, floor shift by 8, then keep the low byte of the sum
    assign rounded = prod_reg + 19'(ROUND_BIAS);
    assign mix     = dst_reg + rounded[15:8];

endmodule

// ----- hdl/alpha_blend_pixel_unit.sv -----
// ============================================================================
// alpha_blend_pixel_unit
// Source-over alpha blend of one RGBA8888 pixel per clock unless the output stalls.
// ============================================================================
// Usage:
//   Input items arrive on s_axis_*: source pixel, mask byte and the current
//   destination pixel in tdata, the span end marker in tlast. Each item gives
//   exactly one result item on m_axis_*: the new destination pixel in tdata,
//   the span end marker copied to tlast.
//   The cfg_* channel writes dest_mode, global_alpha and mask_enable; it is
//   always ready. Write it only while no items are in flight.
// Timing:
//   Four register stages: coverage product, mask scaling, channel products,
//   output register. m_axis_tvalid rises when an accepted item reaches the
//   output register. One item per cycle is sustained while m_axis_tready
//   is high; the coverage multipliers and the four channel multipliers are
//   each used once per item.
// Reset:
//   rst_n clears all valid bits and loads dest_mode 0, global_alpha 255 and
//   mask_enable 0. No clearing pass is needed.
// Stall:
//   When m_axis_tready is low, the output item holds; stages behind it keep
//   filling until every stage holds an item, then s_axis_tready drops. No
//   item is lost or repeated.
// ============================================================================
module alpha_blend_pixel_unit
    import abp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, mask_value,
    // dst_red, dst_green, dst_blue, dst_alpha (lowest bits first)
    input  logic [71:0]        s_axis_tdata,
    input  logic               s_axis_tlast,

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_red, out_green, out_blue, out_alpha (lowest bits first)
    output logic [31:0]        m_axis_tdata,
    output logic               m_axis_tlast,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    dest_mode_t        dest_mode_reg, dest_mode_next;
    logic [CHAN_W-1:0] global_alpha_reg, global_alpha_next;
    logic              mask_enable_reg, mask_enable_next;
    cfg_t              cfg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        dest_mode_next    = dest_mode_reg;
        global_alpha_next = global_alpha_reg;
        mask_enable_next  = mask_enable_reg;
        if (cfg_valid)
        begin
            // index out of range: drop the write
            unique case (cfg_index)
                REG_DEST_MODE:    dest_mode_next    = dest_mode_t'(cfg_data[1:0]);
                REG_GLOBAL_ALPHA: global_alpha_next = cfg_data;
                REG_MASK_ENABLE:  mask_enable_next  = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_mode_reg    <= MODE_RGBA;
            global_alpha_reg <= ALPHA_OPAQUE;
            mask_enable_reg  <= 1'b0;
        end
        else
        begin
            dest_mode_reg    <= dest_mode_next;
            global_alpha_reg <= global_alpha_next;
            mask_enable_reg  <= mask_enable_next;
        end
    end

    assign cfg = '{dest_mode: dest_mode_reg, global_alpha: global_alpha_reg,
                   mask_enable: mask_enable_reg};

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or the stage
    // after it advances.
    // ------------------------------------------------------------------
    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      v3_reg, v3_next;
    logic      vo_reg, vo_next;
    logic      en_out;
    stage_en_t en;

    assign en_out = !vo_reg || m_axis_tready;
    assign en.s3  = !v3_reg || en_out;
    assign en.s2  = !v2_reg || en.s3;
    assign en.s1  = !v1_reg || en.s2;

    assign s_axis_tready = en.s1;

    always_comb
    begin
        v1_next = en.s1  ? s_axis_tvalid : v1_reg;
        v2_next = en.s2  ? v1_reg        : v2_reg;
        v3_next = en.s3  ? v2_reg        : v3_reg;
        vo_next = en_out ? v3_reg        : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    // ------------------------------------------------------------------
    // Unpack the input item and carry the pixel alongside the math
    // ------------------------------------------------------------------
    pixel_t            px_in;
    logic [CHAN_W-1:0] mask_in;
    pixel_t            px1_reg, px2_reg, px3_reg;

    always_comb
    begin
        px_in.src_red   = s_axis_tdata[7:0];
        px_in.src_green = s_axis_tdata[15:8];
        px_in.src_blue  = s_axis_tdata[23:16];
        px_in.src_alpha = s_axis_tdata[31:24];
        px_in.dst_red   = s_axis_tdata[47:40];
        px_in.dst_green = s_axis_tdata[55:48];
        px_in.dst_blue  = s_axis_tdata[63:56];
        px_in.dst_alpha = s_axis_tdata[71:64];
        px_in.span_end  = s_axis_tlast;
    end

    assign mask_in = s_axis_tdata[39:32];

    always_ff @(posedge clk)
    begin
        if (en.s1)
            px1_reg <= px_in;
        if (en.s2)
            px2_reg <= px1_reg;
        if (en.s3)
            px3_reg <= px2_reg;
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2: coverage
    // ------------------------------------------------------------------
    logic [COV_W-1:0] coverage;

    abp_coverage u_coverage
    (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg),
        .src_alpha  (px_in.src_alpha),
        .mask_value (mask_in),
        .coverage   (coverage)
    );

    // ------------------------------------------------------------------
    // Stage 3: channel products; classify coverage
    // ------------------------------------------------------------------
    logic [COV_W-1:0]  alpha_factor;
    logic              full3_reg, zero3_reg;
    logic [CHAN_W-1:0] mix_red, mix_green, mix_blue, mix_alpha;

    // mask byte mode blends its single byte by the global alpha
    assign alpha_factor = (cfg.dest_mode == MODE_MASK) ? {1'b0, cfg.global_alpha}
                                                       : coverage;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            full3_reg <= (coverage >= COV_FULL);
            zero3_reg <= (coverage == '0);
        end
    end

    abp_mix_lane u_mix_red
    (
        .clk    (clk),
        .en     (en),
        .factor (coverage),
        .src    (px2_reg.src_red),
        .dst    (px2_reg.dst_red),
        .mix    (mix_red)
    );

    abp_mix_lane u_mix_green
    (
        .clk    (clk),
        .en     (en),
        .factor (coverage),
        .src    (px2_reg.src_green),
        .dst    (px2_reg.dst_green),
        .mix    (mix_green)
    );

    abp_mix_lane u_mix_blue
    (
        .clk    (clk),
        .en     (en),
        .factor (coverage),
        .src    (px2_reg.src_blue),
        .dst    (px2_reg.dst_blue),
        .mix    (mix_blue)
    );

    abp_mix_lane u_mix_alpha
    (
        .clk    (clk),
        .en     (en),
        .factor (alpha_factor),
        .src    (px2_reg.src_alpha),
        .dst    (px2_reg.dst_alpha),
        .mix    (mix_alpha)
    );

    // ------------------------------------------------------------------
    // Stage 4: select the result and hold it in the output register
    // ------------------------------------------------------------------
    logic [31:0] data_next;
    logic [31:0] data_reg;
    logic        last_reg;

    always_comb
    begin
        data_next = {px3_reg.dst_alpha, px3_reg.dst_blue,
                     px3_reg.dst_green, px3_reg.dst_red};
        unique case (cfg.dest_mode)
            MODE_RGBA, MODE_RGB:
            begin
                if (full3_reg)
                begin
                    data_next[23:0] = {px3_reg.src_blue, px3_reg.src_green,
                                       px3_reg.src_red};
                    if (cfg.dest_mode == MODE_RGBA)
                        data_next[31:24] = ALPHA_OPAQUE;
                end
                else if (!zero3_reg)
                begin
                    data_next[23:0] = {mix_blue, mix_green, mix_red};
                    if (cfg.dest_mode == MODE_RGBA)
                        data_next[31:24] = mix_alpha;
                end
            end
            MODE_INDEX:
            begin
                // copy a nonzero source byte
                if (px3_reg.src_alpha != '0)
                    data_next[31:24] = px3_reg.src_alpha;
            end
            MODE_MASK:
                data_next[31:24] = mix_alpha;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            data_reg <= data_next;
            last_reg <= px3_reg.span_end;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule
